[hw/rtl/fegs_pkg.sv]
// Package for the frame energy silence gate: register map, field widths,
// reset values and shared codes. No dependencies.
package fegs_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ENERGY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_Q8 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN    = 2'd2;

    // register widths
    localparam int NOISE_W = 31;
    localparam int THR_W   = 16;
    localparam int FLEN_W  = 9;

    // register reset values
    localparam logic [NOISE_W-1:0] NOISE_RESET = 31'd1;
    localparam logic [THR_W-1:0]   THR_RESET   = 16'd256;
    localparam logic [FLEN_W-1:0]  FLEN_RESET  = 9'd160;

    // input word kind (tuser)
    localparam logic REQ_DRAIN = 1'b1;

    // cycles for the limit product to settle after reset or a register write
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // result queue depth
    localparam int OQ_DEPTH = 3;

    // what a word in the second stage is
    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_EMIT,
        KIND_DONE
    } kind_t;

endpackage

[hw/rtl/fegs_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old data. No dependencies.
module fegs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        rdata_reg <= mem_reg[raddr];
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/frame_energy_silence_gate_top.sv]
// Top level of the frame energy silence gate: framing, energy test, delay line
// and result queue. Depends on fegs_pkg and fegs_ram.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: sample; tuser: req_type;
//          |     |                    | tlast: last_sample
//  m_      | out | m_tvalid/m_tready  | tdata: kept_sample; tuser: is_sample
//  cfg_    | in  | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// One word per cycle while s_tready is high. A word accepted on s_ is registered
// into stage 1 together with its delay line read; stage 1 runs the energy test
// and pushes any output word into a 3-deep result queue, which drives m_tvalid
// and the m_ payload from its registered entries.
// s_tready is low after reset and after each register write, while the
// threshold * noise * N limit runs through its two multipliers.
// s_tready also drops when the queue plus the word in flight could fill the
// queue; a stalled m_ side thus holds up to 3 results before back-pressure.
// Reset (aresetn low, synchronous) restores the registers and clears framing;
// the delay line is not cleared; while the frame length is unchanged, only written entries are sent.
module frame_energy_silence_gate_top #(
    parameter int MAX_FRAME   = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_we,
    input  logic [fegs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fegs_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                   s_tuser,  // [0] req_type
    input  logic                                   s_tlast,  // last_sample

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,  // [SAMPLE_BITS-1:0] kept_sample
    output logic                                   m_tuser   // [0] is_sample
);

    import fegs_pkg::*;

    localparam int PW    = $clog2(MAX_FRAME);        // delay line address
    localparam int LW    = $clog2(MAX_FRAME + 1);    // holds a frame length
    localparam int CW    = (LW > FLEN_W) ? LW : FLEN_W;
    localparam int TDW   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SQW   = 2 * SAMPLE_BITS;
    localparam int AW    = SQW + LW;                 // frame energy
    localparam int PRW   = THR_W + NOISE_W;
    localparam int LIMW  = PRW + LW;
    localparam int CMPW  = (AW + 8 > LIMW) ? AW + 8 : LIMW;
    localparam int OW    = SAMPLE_BITS + 1;          // queue entry
    localparam int OQ_PW = $clog2(OQ_DEPTH);
    localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

    // ------------------------------------------------------------------
    // configuration registers and the precomputed limit
    // ------------------------------------------------------------------
    logic [NOISE_W-1:0] noise_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [FLEN_W-1:0]  flen_reg;
    logic [1:0]         settle_reg;
    logic [PRW-1:0]     prod_reg;
    logic [LIMW-1:0]    lim_reg;

    logic [CW-1:0]      flen_ext;
    logic [LW-1:0]      n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_reg  <= NOISE_RESET;
            thr_reg    <= THR_RESET;
            flen_reg   <= FLEN_RESET;
            settle_reg <= SETTLE_CYCLES;
        end else begin
            if (cfg_we) begin
                settle_reg <= SETTLE_CYCLES;
                case (cfg_index)
                    CFG_NOISE_ENERGY: noise_reg <= cfg_wdata[NOISE_W-1:0];
                    CFG_THRESHOLD_Q8: thr_reg   <= cfg_wdata[THR_W-1:0];
                    CFG_FRAME_LEN:    flen_reg  <= cfg_wdata[FLEN_W-1:0];
                    default: ;
                endcase
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // effective frame length: 0 acts as 1, clamp at MAX_FRAME
    always_comb begin
        flen_ext = CW'(flen_reg);
        if (flen_reg == '0) begin
            n = LW'(1);
        end else if (flen_ext > CW'(MAX_FRAME)) begin
            n = LW'(MAX_FRAME);
        end else begin
            n = flen_ext[LW-1:0];
        end
    end

    // limit = threshold * noise * N, each multiplier registered in turn
    always_ff @(posedge aclk) begin
        prod_reg <= PRW'(thr_reg) * PRW'(noise_reg);
        lim_reg  <= LIMW'(prod_reg) * LIMW'(n);
    end

    // ------------------------------------------------------------------
    // stage 0: framing state, delay line access, square
    // ------------------------------------------------------------------
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic          primed_reg, primed_next;
    logic [PW-1:0] dcnt_reg, dcnt_next;     // held samples left, valid if keep

    logic [PW-1:0] wp_eff, phase_eff, wp_adv, drain_room;
    logic [LW-1:0] wp_inc, phase_inc;
    logic          phase_wrap;

    logic [SAMPLE_BITS-1:0] smp, mag;
    logic [SQW-1:0]         sq;

    logic          s_accept;
    logic          ram_we;
    logic [SAMPLE_BITS-1:0] ram_q;
    kind_t         kind0;

    // stage 1 / queue signals used by stage 0
    logic            p1_valid_reg;
    kind_t           p1_kind_reg;
    logic            p1_phase0_reg;
    logic            p1_primed_reg;
    logic [SQW-1:0]  p1_sq_reg;
    logic [AW-1:0]   acc_reg, acc_next;
    logic            keep_reg;
    logic [AW-1:0]   sum;
    logic            cmp, judge, keep_next, keep_fwd;
    logic [OQ_CW-1:0] oq_cnt_reg;

    assign s_tready = (settle_reg == 2'd0) &&
                      ((OQ_CW + 1)'(oq_cnt_reg) + (OQ_CW + 1)'(p1_valid_reg)
                       < (OQ_CW + 1)'(OQ_DEPTH));
    assign s_accept = s_tvalid && s_tready;

    // pointers restart at 0 if the frame length was lowered below them
    always_comb begin
        wp_eff     = (LW'(wp_reg) >= n) ? '0 : wp_reg;
        phase_eff  = (LW'(phase_reg) >= n) ? '0 : phase_reg;
        wp_inc     = LW'(wp_eff) + LW'(1);
        phase_inc  = LW'(phase_eff) + LW'(1);
        wp_adv     = (wp_inc >= n) ? '0 : wp_inc[PW-1:0];
        phase_wrap = (phase_inc >= n);
        drain_room = PW'(n - LW'(1) - LW'(phase_eff));
    end

    assign smp = s_tdata[SAMPLE_BITS-1:0];
    assign mag = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
    assign sq  = SQW'(mag) * SQW'(mag);

    // a drain right behind the last sample sees that sample's frame verdict
    assign keep_fwd = judge ? cmp : keep_reg;

    always_comb begin
        wp_next     = wp_reg;
        phase_next  = phase_reg;
        primed_next = primed_reg;
        dcnt_next   = dcnt_reg;
        ram_we      = 1'b0;
        kind0       = KIND_SAMPLE;
        if (s_accept) begin
            if (s_tuser == REQ_DRAIN) begin
                if (keep_fwd && (dcnt_reg != '0)) begin
                    kind0      = KIND_EMIT;
                    wp_next    = wp_adv;
                    phase_next = phase_eff;
                    dcnt_next  = dcnt_reg - PW'(1);
                end else begin
                    kind0       = KIND_DONE;
                    wp_next     = '0;
                    phase_next  = '0;
                    primed_next = 1'b0;
                    dcnt_next   = '0;
                end
            end else begin
                kind0     = KIND_SAMPLE;
                ram_we    = 1'b1;
                wp_next   = wp_adv;
                dcnt_next = '0;
                if (phase_wrap) begin
                    phase_next  = '0;
                    primed_next = 1'b1;
                end else begin
                    phase_next = phase_inc[PW-1:0];
                end
                if (s_tlast) begin
                    dcnt_next   = primed_reg ? drain_room : '0;
                    phase_next  = '0;
                    primed_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            phase_reg    <= '0;
            primed_reg   <= 1'b0;
            dcnt_reg     <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            wp_reg       <= wp_next;
            phase_reg    <= phase_next;
            primed_reg   <= primed_next;
            dcnt_reg     <= dcnt_next;
            p1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_kind_reg   <= kind0;
            p1_phase0_reg <= (phase_eff == '0);
            p1_primed_reg <= primed_reg;
            p1_sq_reg     <= sq;
        end
    end

    // delay line: read the slot before it is overwritten in the same cycle
    fegs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_FRAME)
    ) u_delay (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wp_eff),
        .wdata (smp),
        .raddr (wp_eff),
        .rdata (ram_q)
    );

    // ------------------------------------------------------------------
    // stage 1: energy accumulate, frame test, result select
    // ------------------------------------------------------------------
    logic          push;
    logic          from_ram;
    logic [OW-1:0] push_word;

    assign sum       = acc_reg + AW'(p1_sq_reg);
    assign cmp       = (CMPW'(sum) << 8) > CMPW'(lim_reg);
    assign judge     = p1_valid_reg && (p1_kind_reg == KIND_SAMPLE) &&
                       p1_phase0_reg && p1_primed_reg;
    assign keep_next = judge ? cmp : keep_reg;

    always_comb begin
        acc_next = acc_reg;
        if (p1_valid_reg && (p1_kind_reg == KIND_SAMPLE)) begin
            acc_next = p1_phase0_reg ? AW'(p1_sq_reg) : sum;
        end
    end

    always_comb begin
        push     = 1'b0;
        from_ram = 1'b0;
        if (p1_valid_reg) begin
            case (p1_kind_reg)
                KIND_SAMPLE: begin
                    push     = p1_primed_reg && keep_next;
                    from_ram = 1'b1;
                end
                KIND_EMIT: begin
                    push     = 1'b1;
                    from_ram = 1'b1;
                end
                KIND_DONE: begin
                    push     = 1'b1;
                    from_ram = 1'b0;
                end
                default: begin
                    push     = 1'b0;
                    from_ram = 1'b0;
                end
            endcase
        end
    end

    assign push_word = {from_ram, from_ram ? ram_q : {SAMPLE_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            keep_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            keep_reg <= keep_next;
        end
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    logic [OW-1:0]    oq_mem_reg [OQ_DEPTH];
    logic [OQ_PW-1:0] oq_head_reg, oq_tail_reg;
    logic             pop;

    assign m_tvalid = (oq_cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tuser  = oq_mem_reg[oq_head_reg][OW-1];
    assign m_tdata  = TDW'(oq_mem_reg[oq_head_reg][SAMPLE_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (push) begin
            oq_mem_reg[oq_tail_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_head_reg <= '0;
            oq_tail_reg <= '0;
            oq_cnt_reg  <= '0;
        end else begin
            if (push) begin
                oq_tail_reg <= (oq_tail_reg == OQ_PW'(OQ_DEPTH - 1)) ? '0
                                                                  : oq_tail_reg + OQ_PW'(1);
            end
            if (pop) begin
                oq_head_reg <= (oq_head_reg == OQ_PW'(OQ_DEPTH - 1)) ? '0
                                                                  : oq_head_reg + OQ_PW'(1);
            end
            case ({push, pop})
                2'b10:   oq_cnt_reg <= oq_cnt_reg + OQ_CW'(1);
                2'b01:   oq_cnt_reg <= oq_cnt_reg - OQ_CW'(1);
                default: oq_cnt_reg <= oq_cnt_reg;
            endcase
        end
    end

endmodule
